### hw/rtl/psflt_pkg.sv
// shared types, constants and helpers for the failure lockout table
package psflt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam logic [2:0] ACT_CHECK   = 3'd0;
	localparam logic [2:0] ACT_SUCCESS = 3'd1;
	localparam logic [2:0] ACT_FAILURE = 3'd2;
	localparam logic [2:0] ACT_READ    = 3'd3;
	localparam logic [2:0] ACT_UNLOCK  = 3'd4;
	localparam logic [2:0] ACT_CLEAR   = 3'd5;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_FIXED_MS  = 2'd1;
	localparam logic [1:0] REG_BACKOFF   = 2'd2;

	localparam logic [21:0] MASK22 = 22'h3FFFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] source_addr;
		logic [47:0] now_us;
	} psflt_in_t;

	typedef struct packed {
		logic        allowed;
		logic [21:0] remaining_ms;
		logic [7:0]  fail_count;
	} psflt_out_t;

	// one table row
	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  count;
		logic [47:0] last_us;
		logic [21:0] len_ms;
		logic        locked;
	} psflt_entry_t;

	function automatic logic [21:0] backoff_ms(input logic [7:0] count);
		logic [21:0] r;
		case (count)
			8'd0, 8'd1: r = 22'd1000;
			8'd2:       r = 22'd5000;
			8'd3:       r = 22'd15000;
			8'd4:       r = 22'd30000;
			8'd5:       r = 22'd60000;
			default:    r = 22'd300000;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/psflt_div1000.sv
// divide a lock-end difference by 1000 through a reciprocal multiply, saturated to 22 bits
module psflt_div1000 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [48:0] dividend,
	output logic        done,
	output logic [21:0] quotient
);
	// ceil(2^38 / 1000), exact for every dividend below 2^32
	localparam logic [28:0] RECIP  = 29'd274877907;
	// smallest dividend whose quotient no longer fits in 22 bits
	localparam logic [48:0] SAT_AT = 49'd4194304000;

	logic [31:0] num_s1;
	logic        sat_s1;
	logic        vld_s1;
	logic [60:0] prod_s2;
	logic        sat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= go;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_s1 <= dividend[31:0];
			sat_s1 <= (dividend >= SAT_AT);
		end
		if (vld_s1) begin
			prod_s2 <= 61'(num_s1) * 61'(RECIP);
			sat_s2  <= sat_s1;
		end
	end

	assign quotient = sat_s2 ? psflt_pkg::MASK22 : prod_s2[59:38];
endmodule

### hw/rtl/per_source_failure_lockout_table_core.sv
// top level of the per-source failure lockout table
// a result follows the key scan (one memory read per slot, up to the fill level), then read and
// execute; a locked check adds the divide by 1000. clear all runs a clearing pass over every slot.
// throughput: one item at a time; busy is high from start until the result strobe.
// reset: asynchronous clear of control state, then a clearing pass over every slot during which
// busy stays high. results cannot be stalled by the receiver.
module per_source_failure_lockout_table_core #(
	parameter int TABLE_ENTRIES = psflt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  psflt_pkg::psflt_in_t   in_item,
	output logic                   done,
	output psflt_pkg::psflt_out_t  result,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [21:0]            cfg_data
);
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [FW-1:0] FULL = FW'(TABLE_ENTRIES);

	// state codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;

	// configuration registers
	logic [7:0]  thresh_q;
	logic [21:0] fixed_q;
	logic        backoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= 8'd5;
			fixed_q   <= 22'd30000;
			backoff_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psflt_pkg::REG_THRESHOLD: thresh_q  <= cfg_data[7:0];
				psflt_pkg::REG_FIXED_MS:  fixed_q   <= cfg_data;
				psflt_pkg::REG_BACKOFF:   backoff_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// table memory, one row per slot
	psflt_pkg::psflt_entry_t mem [TABLE_ENTRIES];
	psflt_pkg::psflt_entry_t rd_q;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	psflt_pkg::psflt_entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	logic [2:0]            state_q;
	psflt_pkg::psflt_in_t  item_q;
	logic [FW-1:0]         fill_q;
	logic [AW-1:0]         oldest_q;
	logic [FW-1:0]         idx_q;    // scan pointer
	logic                  rvld_q;   // rd_q holds slot idx_q - 1
	logic [AW-1:0]         slot_q;
	logic                  hit_q;
	logic                  start_pend_q;
	logic                  div_go;
	logic                  div_done;
	logic [48:0]           div_in;
	logic [21:0]           div_quo;
	logic [48:0]           lock_end; // one bit above the time width, the sum can carry
	logic [7:0]            cnt_inc;
	logic [AW-1:0]         fail_slot;
	logic [AW-1:0]         rd_slot;

	assign rd_slot   = AW'(idx_q - FW'(1));
	assign lock_end  = {1'b0, rd_q.last_us} + 49'(rd_q.len_ms * 32'd1000);
	assign cnt_inc   = (hit_q ? rd_q.count : 8'd0) + 8'd1;
	assign fail_slot = hit_q ? slot_q : ((fill_q < FULL) ? AW'(fill_q) : oldest_q);
	assign div_in    = lock_end - {1'b0, item_q.now_us};
	assign busy      = (state_q != ST_IDLE);

	// the found row stays on the read port until the result is out
	always_comb begin
		rd_addr = AW'(idx_q);
		if (state_q == ST_READ || state_q == ST_EXEC || state_q == ST_DIV)
			rd_addr = slot_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = rd_q;
		div_go  = 1'b0;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = AW'(idx_q);
			wr_data = '0;
		end else if (state_q == ST_EXEC) begin
			case (item_q.action)
				psflt_pkg::ACT_CHECK: begin
					if (hit_q && rd_q.locked) begin
						if ({1'b0, item_q.now_us} >= lock_end) begin
							wr_en          = 1'b1;
							wr_data.locked = 1'b0;
							wr_data.count  = 8'd0;
						end else begin
							div_go = 1'b1;
						end
					end
				end
				psflt_pkg::ACT_SUCCESS, psflt_pkg::ACT_UNLOCK: begin
					if (hit_q) begin
						wr_en          = 1'b1;
						wr_data.count  = 8'd0;
						wr_data.locked = 1'b0;
						wr_data.len_ms = 22'd0;
					end
				end
				psflt_pkg::ACT_FAILURE: begin
					wr_en   = 1'b1;
					wr_addr = fail_slot;
					if (!hit_q) begin
						wr_data     = '0;
						wr_data.key = item_q.source_addr;
					end
					wr_data.count   = cnt_inc;
					wr_data.last_us = item_q.now_us;
					if (cnt_inc >= thresh_q) begin
						wr_data.locked = 1'b1;
						wr_data.len_ms = backoff_q ? psflt_pkg::backoff_ms(cnt_inc) : fixed_q;
					end
				end
				default: ;
			endcase
		end
	end

	psflt_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			fill_q   <= '0;
			oldest_q <= '0;
			rvld_q   <= 1'b0;
			hit_q    <= 1'b0;
			slot_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q  <= '0;
						rvld_q <= 1'b0;
						hit_q  <= 1'b0;
						state_q <= (in_item.action == psflt_pkg::ACT_CLEAR) ? ST_CLEAR : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// compare the row read last cycle, issue the next read
					if (rvld_q && rd_q.key == item_q.source_addr) begin
						hit_q   <= 1'b1;
						slot_q  <= rd_slot;
						state_q <= ST_READ;
					end else if (idx_q >= fill_q) begin
						state_q <= ST_READ;
					end else begin
						idx_q  <= idx_q + FW'(1);
						rvld_q <= 1'b1;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (div_go) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
						if (item_q.action == psflt_pkg::ACT_FAILURE && !hit_q) begin
							if (fill_q < FULL)
								fill_q <= fill_q + FW'(1);
							else
								oldest_q <= (oldest_q == AW'(TABLE_ENTRIES - 1)) ? '0
								           : oldest_q + AW'(1);
						end
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					if (idx_q == FW'(TABLE_ENTRIES - 1)) begin
						fill_q   <= '0;
						oldest_q <= '0;
						idx_q    <= '0;
						state_q  <= ST_IDLE;
					end else begin
						idx_q <= idx_q + FW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result strobe: end of execute, end of the divide, or end of a clear-all pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= (state_q == ST_EXEC && !div_go) || (state_q == ST_DIV && div_done)
			        || (state_q == ST_CLEAR && idx_q == FW'(TABLE_ENTRIES - 1) && start_pend_q);
	end

	// marks a clear-all transfer, as opposed to the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_pend_q <= 1'b0;
		else if (state_q == ST_IDLE && start)
			start_pend_q <= (in_item.action == psflt_pkg::ACT_CLEAR);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			item_q <= in_item;
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			result <= '{allowed: 1'b1, remaining_ms: 22'd0, fail_count: 8'd0};
		end else if (state_q == ST_DIV) begin
			result.allowed      <= 1'b0;
			result.remaining_ms <= div_quo;
			result.fail_count   <= rd_q.count;
		end else if (state_q == ST_EXEC) begin
			result.allowed      <= 1'b1;
			result.remaining_ms <= 22'd0;
			case (item_q.action)
				psflt_pkg::ACT_FAILURE:                       result.fail_count <= cnt_inc;
				psflt_pkg::ACT_SUCCESS, psflt_pkg::ACT_UNLOCK: result.fail_count <= 8'd0;
				default: result.fail_count <= hit_q ? wr_data.count : 8'd0;
			endcase
		end
	end

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a transfer in flight");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL) else $error("fill level beyond table size");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider finished outside wait");
endmodule
